### rtl/assert_macros.svh
// assertion macros of the entity decoder rtl
// no dependencies; included by the files that assert

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define XED_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("xed assertion failed");

// property checked on every rising clock edge, reset included
`define XED_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("xed assertion failed, reset included");

`endif

### rtl/xed_pkg.sv
// types and constants of the xml entity decoder
// no dependencies; used by every rtl module of the block

package xed_pkg;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_ENTITY = 2'd1,
        MODE_DRAIN  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_END   = 3'd1,
        ST_HEX_LONG = 3'd2,
        ST_HEX_D1   = 3'd3,
        ST_HEX_D2   = 3'd4,
        ST_DEC_LONG = 3'd5,
        ST_RANGE    = 3'd6,
        ST_NAME     = 3'd7
    } t_status;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 3;
    localparam int ACCUM_W = 16;
    localparam int BODY_W  = 32;

    localparam logic [COUNT_W-1:0] BODY_SAT  = 3'd5;
    localparam logic [COUNT_W-1:0] BODY_KEEP = 3'd4;
    localparam logic [COUNT_W-1:0] HEX_FULL  = 3'd4;
    localparam logic [ACCUM_W-1:0] DEC_BASE  = 16'd10;
    localparam logic [CHAR_W-1:0]  MIN_CHAR  = 8'd32;

    localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              fin;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [CHAR_W-1:0] value;
    } t_dec_res;

    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              char_valid;
        t_status           status;
        logic              done;
    } t_out_word;

endpackage

### rtl/xml_entity_decoder_core.sv
// xml character entity decoder: an accepted byte waits in the input register, is decoded
// combinationally and leaves through the result register; throughput one byte per cycle
// while downstream is ready; an input register and a result register bracket the single
// decode stage, and while a result word waits the input register still takes one word
// bytes that cause no result (entity bodies, draining after an error) are taken at that rate
// i_rst_n synchronous active low: empties both registers, mode back to text, status ok
// depends on xed_pkg, xed_in_reg, xed_decode and assert_macros.svh

`include "assert_macros.svh"

module xml_entity_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte stream in
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,    // [7:0] in_char
    input  logic       i_s_axis_tlast,    // is_final
    // decoded stream out
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,    // [7:0] out_char
    output logic [3:0] o_m_axis_tuser,    // [0] char_valid, [3:1] status
    output logic       o_m_axis_tlast     // string_done
);

    // pipeline control
    logic              w_adv;       // result register can take a word
    logic              w_in_valid;
    xed_pkg::t_in_word w_in;
    logic              w_step;      // held byte is processed this cycle

    // entity state
    xed_pkg::t_mode                r_mode,  n_mode;
    logic [xed_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [xed_pkg::ACCUM_W-1:0]   r_accum, n_accum;
    logic [xed_pkg::BODY_W-1:0]    r_chars, n_chars;
    xed_pkg::t_status              r_err,   n_err;

    // result
    xed_pkg::t_dec_res  w_dec;
    logic               w_emit;
    xed_pkg::t_out_word w_out;
    logic               r_out_valid;
    xed_pkg::t_out_word r_out;

    logic               w_semi;

    // the decode stage moves whenever the result register is empty or being drained
    assign w_adv  = !r_out_valid || i_m_axis_tready;
    assign w_step = w_in_valid && w_adv;
    assign w_semi = (w_in.chr == xed_pkg::CH_SEMI);

    xed_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_adv           (w_adv),
        .o_valid         (w_in_valid),
        .o_word          (w_in)
    );

    // decode always looks at the stored body; only used on a semicolon
    xed_decode u_decode (
        .i_body_chars (r_chars),
        .i_body_count (r_count),
        .i_accum      (r_accum),
        .o_res        (w_dec)
    );

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_accum = r_accum;
        n_chars = r_chars;
        n_err   = r_err;
        unique case (r_mode)
            xed_pkg::MODE_DRAIN: begin
                // swallow everything until the end of the string
            end
            xed_pkg::MODE_ENTITY: begin
                if (w_semi) begin
                    n_count = '0;
                    n_accum = '0;
                    n_chars = '0;
                    if (w_dec.status == xed_pkg::ST_OK) begin
                        n_mode = xed_pkg::MODE_TEXT;
                    end else begin
                        n_mode = xed_pkg::MODE_DRAIN;
                        n_err  = w_dec.status;
                    end
                end else begin
                    // keep the first four body bytes, one lane each
                    for (int i = 0; i < 4; i++) begin
                        if (r_count < xed_pkg::BODY_KEEP && r_count[1:0] == 2'(i)) begin
                            n_chars[8*i +: 8] = w_in.chr;
                        end
                    end
                    // decimal digits after the hash, unchecked, wrapping
                    if (r_count >= 3'd1 && r_count <= 3'd3
                            && r_chars[7:0] == xed_pkg::CH_HASH) begin
                        n_accum = 16'(r_accum * xed_pkg::DEC_BASE
                                      + {8'h00, w_in.chr} - {8'h00, xed_pkg::CH_ZERO});
                    end
                    if (r_count < xed_pkg::BODY_SAT) begin
                        n_count = r_count + 3'd1;
                    end
                end
            end
            default: begin
                // text, and unused codes behave as text
                if (w_in.chr == xed_pkg::CH_AMP) begin
                    n_mode  = xed_pkg::MODE_ENTITY;
                    n_count = '0;
                    n_accum = '0;
                    n_chars = '0;
                end else begin
                    n_mode = xed_pkg::MODE_TEXT;
                end
            end
        endcase
        // the final byte always leaves the block as after reset
        if (w_in.fin) begin
            n_mode  = xed_pkg::MODE_TEXT;
            n_count = '0;
            n_accum = '0;
            n_chars = '0;
            n_err   = xed_pkg::ST_OK;
        end
    end

    // result of the byte
    always_comb begin
        w_emit           = w_in.fin;
        w_out.chr        = 8'h00;
        w_out.char_valid = 1'b0;
        w_out.status     = xed_pkg::ST_OK;
        w_out.done       = w_in.fin;
        unique case (r_mode)
            xed_pkg::MODE_DRAIN: begin
                w_out.status = r_err;
            end
            xed_pkg::MODE_ENTITY: begin
                if (w_semi && w_dec.status == xed_pkg::ST_OK) begin
                    w_emit           = 1'b1;
                    w_out.chr        = w_dec.value;
                    w_out.char_valid = 1'b1;
                end else if (w_semi) begin
                    w_out.status = w_dec.status;
                end else begin
                    w_out.status = xed_pkg::ST_NO_END;
                end
            end
            default: begin
                if (w_in.chr == xed_pkg::CH_AMP) begin
                    w_out.status = xed_pkg::ST_NO_END;
                end else begin
                    // plain byte passes straight through
                    w_emit           = 1'b1;
                    w_out.chr        = w_in.chr;
                    w_out.char_valid = 1'b1;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= xed_pkg::MODE_TEXT;
            r_count <= '0;
            r_accum <= '0;
            r_chars <= '0;
            r_err   <= xed_pkg::ST_OK;
        end else if (w_step) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_accum <= n_accum;
            r_chars <= n_chars;
            r_err   <= n_err;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.chr;
    assign o_m_axis_tuser  = {r_out.status, r_out.char_valid};
    assign o_m_axis_tlast  = r_out.done;

    // draining happens exactly when an error is on record
    `XED_ASSERT(a_drain_err, i_clk, i_rst_n,
        (r_mode == xed_pkg::MODE_DRAIN) == (r_err != xed_pkg::ST_OK))
    // body count saturates
    `XED_ASSERT(a_count_sat, i_clk, i_rst_n, r_count <= xed_pkg::BODY_SAT)
    // a carried byte never comes with an error
    `XED_ASSERT(a_char_ok, i_clk, i_rst_n,
        r_out_valid && r_out.char_valid |-> r_out.status == xed_pkg::ST_OK)
    // an error is only reported at the end of a string
    `XED_ASSERT(a_err_last, i_clk, i_rst_n,
        r_out_valid && r_out.status != xed_pkg::ST_OK |-> r_out.done)
    // after a reset edge nothing is offered downstream
    `XED_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !r_out_valid)

endmodule

### rtl/xed_in_reg.sv
// input register of the entity decoder, one word deep
// depends on xed_pkg

module xed_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // in_char
    input  logic              i_s_axis_tlast,   // is_final
    input  logic              i_adv,
    output logic              o_valid,
    output xed_pkg::t_in_word o_word
);

    logic              r_valid;
    xed_pkg::t_in_word r_word;
    logic              w_take;

    // free when empty or when the held word moves on this cycle
    assign o_s_axis_tready = !r_valid || i_adv;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word.chr <= i_s_axis_tdata;
            r_word.fin <= i_s_axis_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### rtl/xed_decode.sv
// entity body decoder: numeric and named forms to one byte or an error code
// depends on xed_pkg

module xed_decode (
    input  logic [xed_pkg::BODY_W-1:0]  i_body_chars,
    input  logic [xed_pkg::COUNT_W-1:0] i_body_count,
    input  logic [xed_pkg::ACCUM_W-1:0] i_accum,
    output xed_pkg::t_dec_res           o_res
);

    logic [7:0] w_b0, w_b1, w_b2, w_b3;
    logic       w_d1_ok, w_d2_ok;
    logic [3:0] w_d1, w_d2;
    logic [7:0] w_hex_val;

    // hex digit, either case; bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    assign w_b0 = i_body_chars[7:0];
    assign w_b1 = i_body_chars[15:8];
    assign w_b2 = i_body_chars[23:16];
    assign w_b3 = i_body_chars[31:24];

    assign {w_d1_ok, w_d1} = hex_digit(w_b2);
    assign {w_d2_ok, w_d2} = hex_digit(w_b3);
    assign w_hex_val = (i_body_count == xed_pkg::HEX_FULL) ? {w_d1, w_d2} : {4'h0, w_d1};

    always_comb begin
        o_res.status = xed_pkg::ST_OK;
        o_res.value  = 8'h00;
        priority if (w_b0 == xed_pkg::CH_HASH && w_b1 == 8'h78) begin
            // hex form
            priority if (i_body_count > xed_pkg::HEX_FULL) begin
                o_res.status = xed_pkg::ST_HEX_LONG;
            end else if (!w_d1_ok) begin
                o_res.status = xed_pkg::ST_HEX_D1;
            end else if (i_body_count == xed_pkg::HEX_FULL && !w_d2_ok) begin
                o_res.status = xed_pkg::ST_HEX_D2;
            end else if (w_hex_val < xed_pkg::MIN_CHAR) begin
                o_res.status = xed_pkg::ST_RANGE;
            end else begin
                o_res.value = w_hex_val;
            end
        end else if (w_b0 == xed_pkg::CH_HASH) begin
            // decimal form; a set top byte means negative or above 255
            priority if (i_body_count > xed_pkg::BODY_KEEP) begin
                o_res.status = xed_pkg::ST_DEC_LONG;
            end else if (i_accum[15:8] != 8'h00 || i_accum[7:0] < xed_pkg::MIN_CHAR) begin
                o_res.status = xed_pkg::ST_RANGE;
            end else begin
                o_res.value = i_accum[7:0];
            end
        end else if (w_b0 == 8'h61 && w_b1 == 8'h6D && w_b2 == 8'h70) begin
            o_res.value = xed_pkg::CH_AMP;
        end else if (w_b0 == 8'h71 && w_b1 == 8'h75 && w_b2 == 8'h6F && w_b3 == 8'h74) begin
            o_res.value = xed_pkg::CH_QUOTE;
        end else if (w_b0 == 8'h61 && w_b1 == 8'h70 && w_b2 == 8'h6F && w_b3 == 8'h73) begin
            o_res.value = xed_pkg::CH_APOS;
        end else if (w_b0 == 8'h6C && w_b1 == 8'h74) begin
            o_res.value = xed_pkg::CH_LT;
        end else if (w_b0 == 8'h67 && w_b1 == 8'h74) begin
            o_res.value = xed_pkg::CH_GT;
        end else begin
            o_res.status = xed_pkg::ST_NAME;
        end
    end

endmodule

### verif/testbench.sv
// self-checking bench for xml_entity_decoder_core: byte stream in, decoded words out
// holds its own entity decode predictor and compares every output word field by field
// depends on xed_pkg and the rtl of xml_entity_decoder_core

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xed_pkg::*;

    localparam int N_BYTES = 1700;

    // entity shapes for the random part
    typedef enum int {
        ENT_NAMED,
        ENT_HEX,
        ENT_DEC,
        ENT_HEX_LONG,
        ENT_HEX_BAD1,
        ENT_HEX_BAD2,
        ENT_DEC_LONG,
        ENT_RANGE,
        ENT_UNKNOWN,
        ENT_NOISE
    } t_ent_kind;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = '0;    // [7:0] in_char
    logic       i_s_axis_tlast = 1'b0;  // is_final
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;         // [7:0] out_char
    logic [3:0] o_m_axis_tuser;         // [0] char_valid, [3:1] status
    logic       o_m_axis_tlast;         // string_done

    xml_entity_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // stimulus bytes waiting for the driver, and decoded words waiting for the monitor
    t_in_word   text_bytes[$];
    t_out_word  decoded_words[$];
    logic [7:0] str_buf[$];

    t_in_word cur_word;
    int       send_gap = 0;
    int       stall_left = 0;
    int       tx_quiet = 0;
    int       rx_quiet = 0;
    int       n_fail = 0;

    // predictor state
    t_mode       ent_mode = MODE_TEXT;
    logic [2:0]  body_len = '0;
    logic [15:0] dec_accum = '0;
    logic [31:0] body_bytes = '0;
    t_status     first_err = ST_OK;

    initial forever #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'(CH_ZERO);
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void clear_body();
        body_len   = '0;
        dec_accum  = '0;
        body_bytes = '0;
    endfunction

    function automatic void reset_state();
        ent_mode  = MODE_TEXT;
        clear_body();
        first_err = ST_OK;
    endfunction

    function automatic void note_result(logic [7:0] chr, logic valid, t_status st, logic done);
        t_out_word w;
        w.chr        = chr;
        w.char_valid = valid;
        w.status     = st;
        w.done       = done;
        decoded_words.push_back(w);
    endfunction

    // body byte: keep the first four, fold digits 1..3 of a decimal body into the sum
    function automatic void absorb_byte(logic [7:0] c);
        if (body_len < BODY_KEEP) body_bytes[8*body_len +: 8] = c;
        if (body_len >= 1 && body_len <= 3 && body_bytes[7:0] == CH_HASH)
            dec_accum = dec_accum * DEC_BASE + {8'd0, c} - {8'd0, CH_ZERO};
        if (body_len < BODY_SAT) body_len = body_len + 1'b1;
    endfunction

    function automatic t_status decode_entity(output logic [7:0] val);
        logic [7:0] b0, b1, b2, b3;
        int v, d1, d2;
        b0  = body_bytes[7:0];
        b1  = body_bytes[15:8];
        b2  = body_bytes[23:16];
        b3  = body_bytes[31:24];
        val = '0;
        if (b0 == CH_HASH) begin
            if (b1 == "x") begin
                if (body_len > HEX_FULL) return ST_HEX_LONG;
                d1 = hex_nibble(b2);
                if (d1 < 0) return ST_HEX_D1;
                v = d1;
                if (body_len == HEX_FULL) begin
                    d2 = hex_nibble(b3);
                    if (d2 < 0) return ST_HEX_D2;
                    v = v * 16 + d2;
                end
            end else begin
                if (body_len > BODY_KEEP) return ST_DEC_LONG;
                // the sum is read as a signed 16-bit value
                v = int'($signed(dec_accum));
            end
            if (v < int'(MIN_CHAR) || v > 255) return ST_RANGE;
            val = v[7:0];
            return ST_OK;
        end
        if (b0 == "a" && b1 == "m" && b2 == "p") begin
            val = CH_AMP;
            return ST_OK;
        end
        if (b0 == "q" && b1 == "u" && b2 == "o" && b3 == "t") begin
            val = CH_QUOTE;
            return ST_OK;
        end
        if (b0 == "a" && b1 == "p" && b2 == "o" && b3 == "s") begin
            val = CH_APOS;
            return ST_OK;
        end
        if (b0 == "l" && b1 == "t") begin
            val = CH_LT;
            return ST_OK;
        end
        if (b0 == "g" && b1 == "t") begin
            val = CH_GT;
            return ST_OK;
        end
        return ST_NAME;
    endfunction

    // one accepted byte: update the state and queue the word it causes, if any
    function automatic void decode_byte(t_in_word w);
        logic [7:0] val;
        t_status    st;
        if (ent_mode == MODE_DRAIN) begin
            if (w.fin) begin
                note_result('0, 1'b0, first_err, 1'b1);
                reset_state();
            end
        end else if (ent_mode == MODE_ENTITY) begin
            if (w.chr == CH_SEMI) begin
                st = decode_entity(val);
                clear_body();
                if (st == ST_OK) begin
                    ent_mode = MODE_TEXT;
                    note_result(val, 1'b1, ST_OK, w.fin);
                    if (w.fin) reset_state();
                end else if (w.fin) begin
                    note_result('0, 1'b0, st, 1'b1);
                    reset_state();
                end else begin
                    // first error: nothing more until the final byte
                    first_err = st;
                    ent_mode  = MODE_DRAIN;
                end
            end else begin
                absorb_byte(w.chr);
                if (w.fin) begin
                    note_result('0, 1'b0, ST_NO_END, 1'b1);
                    reset_state();
                end
            end
        end else if (w.chr == CH_AMP) begin
            if (w.fin) begin
                note_result('0, 1'b0, ST_NO_END, 1'b1);
                reset_state();
            end else begin
                ent_mode = MODE_ENTITY;
                clear_body();
            end
        end else begin
            ent_mode = MODE_TEXT;
            note_result(w.chr, 1'b1, ST_OK, w.fin);
            if (w.fin) reset_state();
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    // idle length: mostly none, a few long ones, and quiet runs with no idling at all
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 15) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 600) return 0;
        if (r < 900) return $urandom_range(1, 3);
        if (r < 985) return $urandom_range(4, 12);
        return $urandom_range(15, 50);
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] n, bit upper);
        if (n < 10) return CH_ZERO + n;
        return 8'((upper ? "A" : "a") + n - 10);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    endfunction

    // move the collected string to the driver queue, last byte marked final
    function automatic void flush_string();
        t_in_word w;
        for (int i = 0; i < str_buf.size(); i++) begin
            w.chr = str_buf[i];
            w.fin = (i == str_buf.size() - 1);
            text_bytes.push_back(w);
        end
        str_buf.delete();
    endfunction

    function automatic logic [7:0] rand_body();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_SEMI);
        return c;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do c = rand_body(); while (hex_nibble(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        // a stray ampersand now and then opens an entity by accident
        do c = 8'($urandom_range(1, 255)); while (c == CH_AMP && $urandom_range(0, 19) != 0);
        return c;
    endfunction

    function automatic void add_number(int v, int ndig);
        int p;
        for (int k = ndig - 1; k >= 0; k--) begin
            p = 1;
            for (int j = 0; j < k; j++) p = p * 10;
            str_buf.push_back(CH_ZERO + 8'((v / p) % 10));
        end
    endfunction

    function automatic void add_rand_hex(int n);
        for (int i = 0; i < n; i++)
            str_buf.push_back(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    endfunction

    function automatic void add_entity();
        int        r, v, n;
        t_ent_kind kind;
        r = $urandom_range(0, 99);
        if (r < 25) kind = ENT_NAMED;
        else if (r < 40) kind = ENT_HEX;
        else if (r < 55) kind = ENT_DEC;
        else if (r < 60) kind = ENT_HEX_LONG;
        else if (r < 65) kind = ENT_HEX_BAD1;
        else if (r < 70) kind = ENT_HEX_BAD2;
        else if (r < 75) kind = ENT_DEC_LONG;
        else if (r < 83) kind = ENT_RANGE;
        else if (r < 90) kind = ENT_UNKNOWN;
        else kind = ENT_NOISE;
        str_buf.push_back(CH_AMP);
        case (kind)
            ENT_NAMED: begin
                case ($urandom_range(0, 4))
                    0: add_text("amp");
                    1: add_text("quot");
                    2: add_text("apos");
                    3: add_text("lt");
                    default: add_text("gt");
                endcase
                // trailing body bytes are ignored by the name match
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) str_buf.push_back(rand_body());
                end
            end
            ENT_HEX: begin
                v = $urandom_range(32, 255);
                add_text("#x");
                str_buf.push_back(hex_digit(v[7:4], 1'($urandom_range(0, 1))));
                str_buf.push_back(hex_digit(v[3:0], 1'($urandom_range(0, 1))));
            end
            ENT_DEC: begin
                v = $urandom_range(32, 255);
                str_buf.push_back(CH_HASH);
                add_number(v, (v < 100 && $urandom_range(0, 1)) ? 2 : 3);
            end
            ENT_HEX_LONG: begin
                add_text("#x");
                add_rand_hex($urandom_range(3, 5));
            end
            ENT_HEX_BAD1: begin
                add_text("#x");
                str_buf.push_back(rand_non_hex());
                if ($urandom_range(0, 1)) add_rand_hex(1);
            end
            ENT_HEX_BAD2: begin
                add_text("#x");
                add_rand_hex(1);
                str_buf.push_back(rand_non_hex());
            end
            ENT_DEC_LONG: begin
                str_buf.push_back(CH_HASH);
                add_number($urandom_range(0, 99999), $urandom_range(4, 6));
            end
            ENT_RANGE: begin
                case ($urandom_range(0, 3))
                    0: begin
                        str_buf.push_back(CH_HASH);
                        add_number($urandom_range(0, 31), 2);
                    end
                    1: begin
                        str_buf.push_back(CH_HASH);
                        add_number($urandom_range(256, 999), 3);
                    end
                    2: begin
                        add_text("#x");
                        add_rand_hex(1);
                    end
                    default: str_buf.push_back(CH_HASH);
                endcase
            end
            ENT_UNKNOWN: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) str_buf.push_back(8'($urandom_range("a", "z")));
            end
            default: begin
                // arbitrary body, digit check and sign of the sum included
                if ($urandom_range(0, 1)) str_buf.push_back(CH_HASH);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) str_buf.push_back(rand_body());
            end
        endcase
        str_buf.push_back(CH_SEMI);
    endfunction

    // ---------------------------------------------------------------- driver

    // one word per handshake; prediction runs on the word just accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) decode_byte(cur_word);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (text_bytes.size() != 0) begin
                    cur_word = text_bytes.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= cur_word.chr;
                    i_s_axis_tlast  <= cur_word.fin;
                    send_gap = pick_gap(tx_quiet);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_out_word got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tuser[3:1], o_m_axis_tlast};
                if (decoded_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h %b %0d %b",
                             $time, got.chr, got.char_valid, got.status, got.done);
                    n_fail++;
                end else begin
                    want = decoded_words.pop_front();
                    if (got.chr != want.chr) begin
                        $display("%0t: out_char expected %h actual %h",
                                 $time, want.chr, got.chr);
                        n_fail++;
                    end
                    if (got.char_valid != want.char_valid) begin
                        $display("%0t: char_valid expected %b actual %b",
                                 $time, want.char_valid, got.char_valid);
                        n_fail++;
                    end
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        n_fail++;
                    end
                    if (got.done != want.done) begin
                        $display("%0t: string_done expected %b actual %b",
                                 $time, want.done, got.done);
                        n_fail++;
                    end
                end
            end
            // receiver stalls after a taken word
            if (stall_left > 0) stall_left--;
            else if (o_m_axis_tvalid && i_m_axis_tready) stall_left = pick_gap(rx_quiet);
            i_m_axis_tready <= (stall_left == 0);
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int nseg;

        // plain extremes, zero byte included, final on 0xff
        str_buf.push_back(8'h01);
        str_buf.push_back(8'h00);
        str_buf.push_back(8'hFF);
        flush_string();
        // all names, extra body bytes, final on a good semicolon
        add_text("&amp;&quot;&apos;&lt;&gt;&ampxyz;&lts;");
        flush_string();
        // good numerics, both hex cases, range edges
        add_text("&#x2A;&#x7e;&#65;&#032;&#255;&#xFf;");
        flush_string();
        // empty hex body, then drain to the final byte
        add_text("&#x;ab");
        flush_string();
        add_text("&#x4g;");
        flush_string();
        add_text("&#x414;z");
        flush_string();
        add_text("&#1234;");
        flush_string();
        add_text("&#9;");
        flush_string();
        add_text("&#;");
        flush_string();
        add_text("&#256;");
        flush_string();
        // unknown name, later entity swallowed by the drain
        add_text("&foo;&lt;");
        flush_string();
        // strings ending inside an entity
        add_text("q&#x");
        flush_string();
        add_text("&");
        flush_string();

        // random strings: mostly well-formed entities between plain runs
        while (text_bytes.size() < N_BYTES) begin
            nseg = $urandom_range(1, 6);
            for (int s = 0; s < nseg; s++) begin
                if ($urandom_range(0, 1)) begin
                    for (int i = $urandom_range(1, 5); i > 0; i--)
                        str_buf.push_back(rand_plain());
                end else begin
                    add_entity();
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                str_buf.push_back(CH_AMP);
                for (int i = $urandom_range(0, 3); i > 0; i--) str_buf.push_back(rand_body());
            end
            flush_string();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all bytes taken and all words back before the verdict
        while (text_bytes.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (decoded_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/xed_pkg.sv
rtl/xed_in_reg.sv
rtl/xed_decode.sv
rtl/xml_entity_decoder_core.sv
verif/testbench.sv
